// ===== rtl/lphs_pkg.sv =====
package lphs_pkg;

   // Table geometry.
   localparam int TABLE_SIZE = 1024;
   localparam int KEY_BITS   = 32;
   localparam int SLOT_BITS  = $clog2(TABLE_SIZE);
   localparam int COUNT_BITS = $clog2(TABLE_SIZE + 1);

   // Widths of the fixed port fields.
   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 10;
   localparam int LIVE_W   = 11;
   localparam int LIMIT_W  = 11;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   // Write port of the slot table.
   typedef struct packed {
      logic                 key_we;
      logic                 mark_we;
      logic [SLOT_BITS-1:0] addr;
      logic [KEY_BITS-1:0]  key;
      logic                 used;
      logic                 live;
   } tbl_wr_type;

   // Registered read data of the slot table.
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic                used;
      logic                live;
   } tbl_rd_type;

endpackage

// ===== rtl/linear_probe_hash_set.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    opcode, key
// rsp_      out        rsp_valid/stall    status, slot, live_count
// csr_      in         csr_we             wdata (live limit)
//
// The probe walk reads one slot per cycle from the single read port of the
// slot table. A rejected insert or an unknown opcode is answered without a
// probe walk. After reset a clearing pass zeroes the slot marks; requests
// are stalled during it, while live limit writes are taken as ever.
// The response register frees the request side: a stalled response holds a
// finished request back only when the next one is ready to answer.
module linear_probe_hash_set (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lphs_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [lphs_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lphs_pkg::STATUS_W-1:0] rsp_status,
   output logic [lphs_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [lphs_pkg::LIVE_W-1:0]   rsp_live_count,
   input  logic                          csr_we,
   input  logic [lphs_pkg::LIMIT_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_PROBE = 4'b0100,
      S_SKIP  = 4'b1000
   } state_type;

   localparam logic [lphs_pkg::SLOT_BITS-1:0] LAST_SLOT =
      lphs_pkg::SLOT_BITS'(lphs_pkg::TABLE_SIZE - 1);
   localparam logic [lphs_pkg::COUNT_BITS-1:0] COUNT_MAX =
      lphs_pkg::COUNT_BITS'(lphs_pkg::TABLE_SIZE);

   state_type                          state_ff, state_in;
   logic [lphs_pkg::SLOT_BITS-1:0]     clr_ff, clr_in;
   logic [lphs_pkg::SLOT_BITS-1:0]     pos_ff, pos_in;
   logic [lphs_pkg::SLOT_BITS-1:0]     lap_ff, lap_in;
   logic [lphs_pkg::OPCODE_W-1:0]      op_ff, op_in;
   logic [lphs_pkg::KEY_BITS-1:0]      key_ff, key_in;
   logic [lphs_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic [lphs_pkg::LIMIT_W-1:0]       limit_ff, limit_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lphs_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [lphs_pkg::SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [lphs_pkg::LIVE_W-1:0]        rsp_live_count_ff, rsp_live_count_in;

   logic                               rd_en;
   logic [lphs_pkg::SLOT_BITS-1:0]     rd_addr;
   lphs_pkg::tbl_wr_type               wr;
   lphs_pkg::tbl_rd_type               rd;

   logic                               out_free;
   logic                               ins_ok;
   logic [lphs_pkg::SLOT_BITS-1:0]     home;
   logic [lphs_pkg::SLOT_BITS-1:0]     pos_next;
   logic                               last_lap;
   logic                               probe_done;
   logic [lphs_pkg::STATUS_W-1:0]      probe_status;

   lphs_table u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd      (rd)
   );

   // The response register can take a new result this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Room for one more live entry under the limit and in the table.
   assign ins_ok = ({1'b0, count_ff} + 1'b1 <= {1'b0, limit_ff}) && (count_ff < COUNT_MAX);

   // Home slot is the key modulo the table size, a power of two.
   assign home     = req_key[lphs_pkg::SLOT_BITS-1:0];
   assign pos_next = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign last_lap = (lap_ff == LAST_SLOT);

   // Decide the slot just read: stop with a status, or walk on.
   always_comb begin
      probe_done   = 1'b0;
      probe_status = lphs_pkg::STAT_MISS;
      case (op_ff)
         lphs_pkg::OP_INSERT: begin
            if (!rd.live) begin
               probe_done   = 1'b1;
               probe_status = lphs_pkg::STAT_OK;
            end else if (last_lap) begin
               probe_done   = 1'b1;
               probe_status = lphs_pkg::STAT_FULL;
            end
         end
         lphs_pkg::OP_DELETE, lphs_pkg::OP_FIND: begin
            if (!rd.used) begin
               probe_done = 1'b1;
            end else if (rd.live && rd.key == key_ff) begin
               probe_done   = 1'b1;
               probe_status = lphs_pkg::STAT_OK;
            end else if (last_lap) begin
               probe_done = 1'b1;
            end
         end
         default: begin
            probe_done = 1'b1;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in          = state_ff;
      clr_in            = clr_ff;
      pos_in            = pos_ff;
      lap_in            = lap_ff;
      op_in             = op_ff;
      key_in            = key_ff;
      count_in          = count_ff;
      limit_in          = csr_we ? csr_wdata : limit_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_live_count_in = rsp_live_count_ff;
      rd_en             = 1'b0;
      rd_addr           = pos_next;
      wr                = '0;
      wr.addr           = pos_ff;
      wr.key            = key_ff;

      case (state_ff)
         S_CLEAR: begin
            wr.mark_we = 1'b1;
            wr.addr    = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               key_in = req_key[lphs_pkg::KEY_BITS-1:0];
               pos_in = home;
               lap_in = '0;
               if ((req_opcode == lphs_pkg::OP_INSERT && ins_ok) ||
                   req_opcode == lphs_pkg::OP_DELETE ||
                   req_opcode == lphs_pkg::OP_FIND) begin
                  rd_en    = 1'b1;
                  rd_addr  = home;
                  state_in = S_PROBE;
               end else begin
                  state_in = S_SKIP;
               end
            end
         end
         S_SKIP: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = (op_ff == lphs_pkg::OP_INSERT) ?
                                   lphs_pkg::STAT_FULL : lphs_pkg::STAT_MISS;
               rsp_slot_in       = '0;
               rsp_live_count_in = lphs_pkg::LIVE_W'(count_ff);
               state_in          = S_IDLE;
            end
         end
         S_PROBE: begin
            if (!probe_done) begin
               rd_en  = 1'b1;
               pos_in = pos_next;
               lap_in = lap_ff + 1'b1;
            end else if (out_free) begin
               // Commit the table update together with the response.
               if (probe_status == lphs_pkg::STAT_OK) begin
                  if (op_ff == lphs_pkg::OP_INSERT) begin
                     wr.key_we  = 1'b1;
                     wr.mark_we = 1'b1;
                     wr.used    = 1'b1;
                     wr.live    = 1'b1;
                     count_in   = count_ff + 1'b1;
                  end else if (op_ff == lphs_pkg::OP_DELETE) begin
                     wr.mark_we = 1'b1;
                     wr.used    = 1'b1;
                     wr.live    = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
               rsp_valid_in      = 1'b1;
               rsp_status_in     = probe_status;
               rsp_slot_in       = (probe_status == lphs_pkg::STAT_OK) ?
                                   lphs_pkg::SLOT_W'(pos_ff) : '0;
               rsp_live_count_in = lphs_pkg::LIVE_W'(count_in);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         limit_ff     <= lphs_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff            <= pos_in;
      lap_ff            <= lap_in;
      op_ff             <= op_in;
      key_ff            <= key_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_live_count_ff <= rsp_live_count_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_live_count = rsp_live_count_ff;

endmodule

// ===== rtl/lphs_table.sv =====
module lphs_table (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [lphs_pkg::SLOT_BITS-1:0] rd_addr,
   input  lphs_pkg::tbl_wr_type           wr,
   output lphs_pkg::tbl_rd_type           rd
);

   // Keys are only read back at live slots, so they need no clearing.
   logic [lphs_pkg::KEY_BITS-1:0] key_mem [lphs_pkg::TABLE_SIZE];
   // Each mark word holds the used-ever bit over the live bit.
   logic [1:0]                    mark_mem [lphs_pkg::TABLE_SIZE];

   logic [lphs_pkg::KEY_BITS-1:0] rd_key_ff;
   logic [1:0]                    rd_mark_ff;

   // Key store with a registered read port.
   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[wr.addr] <= wr.key;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   // Mark store with a registered read port.
   always_ff @(posedge clock) begin
      if (wr.mark_we) begin
         mark_mem[wr.addr] <= {wr.used, wr.live};
      end
      if (rd_en) begin
         rd_mark_ff <= mark_mem[rd_addr];
      end
   end

   assign rd.key  = rd_key_ff;
   assign rd.used = rd_mark_ff[1];
   assign rd.live = rd_mark_ff[0];

endmodule

// ===== rtl/lphs_checker.sv =====
module lphs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lphs_pkg::STATUS_W-1:0] rsp_status,
   input logic [lphs_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [lphs_pkg::LIVE_W-1:0]   rsp_live_count
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot) && $stable(rsp_live_count))
      else $error("stalled response changed");

   // A failed request reports slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lphs_pkg::STAT_OK |-> rsp_slot == '0)
      else $error("slot not zero on a failed request");

   // The live count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_live_count <= lphs_pkg::LIVE_W'(lphs_pkg::TABLE_SIZE))
      else $error("live count beyond table size");

   // The clearing pass stalls requests right after reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request taken during the clearing pass");

   // A request accepted from idle is answered no sooner than the next edge.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response appeared in the accept cycle");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);

// ===== tb/sv/linear_probe_hash_set_tb.sv =====
module linear_probe_hash_set_tb;
   import lphs_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int POOL_DEPTH = 64;

   // One expected response.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [LIVE_W-1:0]   live_count;
   } answer_type;

   typedef enum logic {ROW_REQUEST, ROW_LIMIT} row_kind_type;

   // A directed row is either a request or a write of the live limit.
   typedef struct {
      row_kind_type        kind;
      logic [OPCODE_W-1:0] op;
      logic [KEY_W-1:0]    value;
      bit                  typed;
      answer_type          want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OPCODE_W-1:0]   req_opcode = OP_INSERT;
   logic [KEY_W-1:0]      req_key = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot;
   logic [LIVE_W-1:0]     rsp_live_count;
   logic                  csr_we = 1'b0;
   logic [LIMIT_W-1:0]    csr_wdata = '0;

   // Shadow copy of the slot table and the live limit.
   bit [KEY_W-1:0]        slot_key [TABLE_SIZE];
   bit                    slot_used [TABLE_SIZE];
   bit                    slot_live [TABLE_SIZE];
   int unsigned           live_total = 0;
   logic [LIMIT_W-1:0]    limit_reg = LIMIT_RESET;

   answer_type            answers_due [$];
   logic [KEY_W-1:0]      key_pool [$];
   answer_type            due;
   int unsigned           req_calm = 0;
   int unsigned           rsp_calm = 0;
   int unsigned           rsp_wait = 0;
   int                    mismatches = 0;
   int                    cycle_count;

   // Opening rows cover empty-table misses, the unused opcode, collisions,
   // wrap from the last slot, dead slots on the probe path and the limit.
   stim_row_type directed_rows [24] = '{
      '{ROW_REQUEST, OP_FIND,   32'h0000_0000, 1'b1, '{STAT_MISS, 10'd0, 11'd0}},
      '{ROW_REQUEST, OP_DELETE, 32'hFFFF_FFFF, 1'b1, '{STAT_MISS, 10'd0, 11'd0}},
      '{ROW_REQUEST, OP_UNUSED, 32'h0000_0005, 1'b1, '{STAT_MISS, 10'd0, 11'd0}},
      '{ROW_REQUEST, OP_INSERT, 32'h0000_0000, 1'b1, '{STAT_OK, 10'd0, 11'd1}},
      '{ROW_REQUEST, OP_INSERT, 32'h0000_0400, 1'b0, '0},
      '{ROW_REQUEST, OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{STAT_OK, 10'd1023, 11'd3}},
      '{ROW_REQUEST, OP_INSERT, 32'hFFFF_FBFF, 1'b0, '0},
      '{ROW_REQUEST, OP_FIND,   32'h0000_0400, 1'b0, '0},
      '{ROW_REQUEST, OP_DELETE, 32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST, OP_FIND,   32'h0000_0400, 1'b0, '0},
      '{ROW_REQUEST, OP_FIND,   32'h0000_0000, 1'b0, '0},
      '{ROW_REQUEST, OP_INSERT, 32'h0000_0800, 1'b0, '0},
      '{ROW_REQUEST, OP_DELETE, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REQUEST, OP_FIND,   32'hFFFF_FBFF, 1'b0, '0},
      '{ROW_LIMIT,   OP_INSERT, 32'd0,         1'b0, '0},
      '{ROW_REQUEST, OP_INSERT, 32'h1234_5678, 1'b1, '{STAT_FULL, 10'd0, 11'd3}},
      '{ROW_LIMIT,   OP_INSERT, 32'd3,         1'b0, '0},
      '{ROW_REQUEST, OP_INSERT, 32'hAAAA_5555, 1'b1, '{STAT_FULL, 10'd0, 11'd3}},
      '{ROW_LIMIT,   OP_INSERT, 32'd4,         1'b0, '0},
      '{ROW_REQUEST, OP_INSERT, 32'h5555_AAAA, 1'b0, '0},
      '{ROW_REQUEST, OP_INSERT, 32'h8000_0000, 1'b1, '{STAT_FULL, 10'd0, 11'd4}},
      '{ROW_LIMIT,   OP_INSERT, 32'd2047,      1'b0, '0},
      '{ROW_REQUEST, OP_FIND,   32'h5555_AAAA, 1'b0, '0},
      '{ROW_REQUEST, OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{STAT_MISS, 10'd0, 11'd4}}
   };

   linear_probe_hash_set dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_live_count (rsp_live_count),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // Applies one request to the shadow table and returns its response.
   function automatic answer_type hash_set_apply(logic [OPCODE_W-1:0] op,
                                                 logic [KEY_W-1:0] key);
      answer_type  r;
      int unsigned pos;
      int unsigned n;
      int          hit;
      r.status = STAT_MISS;
      r.slot = '0;
      pos = key % TABLE_SIZE;
      hit = -1;
      if (op == OP_INSERT) begin
         r.status = STAT_FULL;
         if (live_total + 1 <= limit_reg && live_total < TABLE_SIZE) begin
            // The first slot that is not live takes the key.
            for (n = 0; n < TABLE_SIZE; n++) begin
               if (!slot_live[pos]) begin
                  slot_key[pos] = key;
                  slot_used[pos] = 1'b1;
                  slot_live[pos] = 1'b1;
                  live_total++;
                  r.status = STAT_OK;
                  r.slot = SLOT_W'(pos);
                  break;
               end
               pos = (pos + 1) % TABLE_SIZE;
            end
         end
      end else if (op == OP_DELETE || op == OP_FIND) begin
         // The search ends at a never-used slot or after one lap.
         for (n = 0; n < TABLE_SIZE; n++) begin
            if (!slot_used[pos]) break;
            if (slot_live[pos] && slot_key[pos] == key) begin
               hit = pos;
               break;
            end
            pos = (pos + 1) % TABLE_SIZE;
         end
         if (hit >= 0) begin
            r.status = STAT_OK;
            r.slot = SLOT_W'(hit);
            if (op == OP_DELETE) begin
               slot_live[hit] = 1'b0;
               if (live_total > 0) live_total--;
            end
         end
      end
      r.live_count = LIVE_W'(live_total);
      return r;
   endfunction

   // Random wait, with occasional stretches of no waiting at all.
   function automatic int unsigned draw_wait(inout int unsigned calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // Keys mostly land in a narrow window of home slots or repeat earlier ones.
   function automatic logic [KEY_W-1:0] draw_key(int unsigned home_base);
      logic [KEY_W-1:0] k;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      k = $urandom();
      if (pick < 5) return k;
      if (pick < 55 && key_pool.size() > 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      k[SLOT_BITS-1:0] = SLOT_BITS'((home_base + $urandom_range(0, 47)) % TABLE_SIZE);
      return k;
   endfunction

   // Presents one request, waits for it to be taken and records its response.
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                               input bit typed, input answer_type want);
      answer_type  got;
      int unsigned gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_key <= key;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      got = hash_set_apply(op, key);
      answers_due.push_back(typed ? want : got);
      if (op == OP_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
   endtask

   // The live limit is only written once every response is back.
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_reg = value;
   endtask

   // Random mix of inserts, deletes, finds and the unused opcode.
   task automatic run_mix(input int unsigned count, input int unsigned home_base);
      int unsigned         pick;
      logic [OPCODE_W-1:0] op;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) op = OP_INSERT;
         else if (pick < 72) op = OP_DELETE;
         else if (pick < 96) op = OP_FIND;
         else op = OP_UNUSED;
         send_request(op, draw_key(home_base), 1'b0, '0);
      end
   endtask

   // Response side: check each response and stall at random afterwards.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response: status %0d slot %0d live %0d",
                     $time, rsp_status, rsp_slot, rsp_live_count);
            mismatches++;
         end else begin
            due = answers_due.pop_front();
            if (rsp_status !== due.status) begin
               $display("%0t: status expected %0d, actual %0d", $time, due.status, rsp_status);
               mismatches++;
            end
            if (rsp_slot !== due.slot) begin
               $display("%0t: slot expected %0d, actual %0d", $time, due.slot, rsp_slot);
               mismatches++;
            end
            if (rsp_live_count !== due.live_count) begin
               $display("%0t: live count expected %0d, actual %0d",
                        $time, due.live_count, rsp_live_count);
               mismatches++;
            end
         end
         rsp_wait = draw_wait(rsp_calm);
      end
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Stops a hung run.
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned      phase_limits [6];
      int unsigned      free_ptr;
      logic [KEY_W-1:0] fill_key;
      phase_limits = '{1, 24, 96, 700, 2, 320};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_LIMIT)
            write_limit(directed_rows[i].value[LIMIT_W-1:0]);
         else
            send_request(directed_rows[i].op, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases, each under its own limit and around its own home window.
      foreach (phase_limits[p]) begin
         write_limit(LIMIT_W'(phase_limits[p]));
         run_mix(115, (p == 0) ? TABLE_SIZE - 24 : $urandom_range(0, TABLE_SIZE - 1));
      end

      // Fill every slot, each request landing on a free home slot.
      write_limit(LIMIT_W'(TABLE_SIZE));
      free_ptr = 0;
      while (live_total < TABLE_SIZE) begin
         while (slot_live[free_ptr]) free_ptr++;
         fill_key = $urandom();
         fill_key[SLOT_BITS-1:0] = SLOT_BITS'(free_ptr);
         send_request(OP_INSERT, fill_key, 1'b0, '0);
      end

      // Full table: rejected by the limit, then with no free slot at all.
      send_request(OP_INSERT, $urandom(), 1'b1,
                   '{STAT_FULL, SLOT_W'(0), LIVE_W'(TABLE_SIZE)});
      write_limit('1);
      send_request(OP_INSERT, $urandom(), 1'b1,
                   '{STAT_FULL, SLOT_W'(0), LIVE_W'(TABLE_SIZE)});

      // Every slot is used now, so misses walk a full lap.
      send_request(OP_FIND, $urandom(), 1'b0, '0);
      send_request(OP_DELETE, $urandom(), 1'b0, '0);
      run_mix(30, $urandom_range(0, TABLE_SIZE - 1));

      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (TABLE_SIZE + 64) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
